>>> rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int OPER_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COLF_W  = 7;
  localparam int LINEF_W = 5;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam logic [OPER_W-1:0] OP_PUT_CHAR    = 3'd0;
  localparam logic [OPER_W-1:0] OP_BACKSPACE   = 3'd1;
  localparam logic [OPER_W-1:0] OP_CLEAR       = 3'd2;
  localparam logic [OPER_W-1:0] OP_MOVE_CURSOR = 3'd3;
  localparam logic [OPER_W-1:0] OP_READ_CELL   = 3'd4;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] DEF_ATTR_RESET = 8'h07;

  localparam logic [1:0] KIND_IMM    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_SCROLL = 2'd3;

  localparam logic [1:0] SCAN_INIT   = 2'd0;
  localparam logic [1:0] SCAN_CLEAR  = 2'd1;
  localparam logic [1:0] SCAN_SCROLL = 2'd2;

  localparam logic OUT_SRC_NXT = 1'b0;
  localparam logic OUT_SRC_CUR = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       scan_start;
    logic       scan_run;
    logic [1:0] scan_mode;
    logic       out_load;
    logic       out_src;
    logic       out_rd;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scan_last;
    logic       out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tcw_cmd_if.sv
// Command channel interface of the text console writer.
`default_nettype none

interface tcw_cmd_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPER_W-1:0]  operation;
  logic [CHAR_W-1:0]  character;
  logic [ATTR_W-1:0]  attribute;
  logic               use_cursor;
  logic [COLF_W-1:0]  column;
  logic [LINEF_W-1:0] line;

  modport source (output valid, operation, character, attribute, use_cursor, column, line,
                  input ready);
  modport sink   (input valid, operation, character, attribute, use_cursor, column, line,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcw_res_if.sv
// Result channel interface of the text console writer.
`default_nettype none

interface tcw_res_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLF_W-1:0]  cursor_column;
  logic [LINEF_W-1:0] cursor_line;
  logic [CHAR_W-1:0]  cell_char;
  logic [ATTR_W-1:0]  cell_attr;

  modport source (output valid, cursor_column, cursor_line, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_line, cell_char, cell_attr,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcw_ctrl.sv
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t      cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_CLEAR   = 3'd3;
  localparam logic [2:0] S_SCROLL  = 3'd4;
  localparam logic [2:0] S_HOLD    = 3'd5;
  localparam logic [2:0] S_HOLD_RD = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_INIT;
        if (stat.scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.kind)
            KIND_IMM: begin
              if (stat.out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_src  = OUT_SRC_NXT;
              end else begin
                state_nxt = S_HOLD;
              end
            end
            KIND_READ: state_nxt = S_READ;
            KIND_CLEAR: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_CLEAR;
            end
            KIND_SCROLL: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCROLL;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = OUT_SRC_CUR;
          cmd.out_rd   = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_HOLD_RD;
        end
      end
      S_CLEAR, S_SCROLL: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = (state_r == S_CLEAR) ? SCAN_CLEAR : SCAN_SCROLL;
        if (stat.scan_last) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = OUT_SRC_CUR;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD, S_HOLD_RD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = OUT_SRC_CUR;
          cmd.out_rd   = (state_r == S_HOLD_RD);
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/tcw_dpath.sv
// Datapath of the text console writer: cursor, cell grid memory, scan counter and result register.
`default_nettype none

module tcw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
  input  wire logic [tcw_pkg::OPER_W-1:0]  in_operation,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  in_character,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  in_attribute,
  input  wire logic                        in_use_cursor,
  input  wire logic [tcw_pkg::COLF_W-1:0]  in_column,
  input  wire logic [tcw_pkg::LINEF_W-1:0] in_line,
  input  wire tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_stat_t               stat,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [tcw_pkg::COLF_W-1:0]       out_cursor_column,
  output logic [tcw_pkg::LINEF_W-1:0]      out_cursor_line,
  output logic [tcw_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]       out_cell_attr
);
  import tcw_pkg::*;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [ATTR_W-1:0] def_attr_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_nxt;
  logic [1:0]        stat_kind;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic [CNT_W-1:0]  scan_prev;
  logic [CNT_W-1:0]  scan_src;
  logic              scan_last;
  logic              out_valid_r;
  logic [COLF_W-1:0]  out_col_r;
  logic [LINEF_W-1:0] out_row_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [ATTR_W-1:0]  out_attr_r;

  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;
  logic [COL_W-1:0]  t_col;
  logic [ROW_W-1:0]  t_row;
  logic [ADDR_W-1:0] t_addr;
  logic              is_nl;
  logic              wrap;
  logic              row_ovf;
  logic [COL_W-1:0]  pc_col;
  logic [ROW_W-1:0]  pc_row;
  logic [ATTR_W-1:0] eff_attr;
  logic              at_origin;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [ADDR_W-1:0] bs_addr;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_q;
  logic [CELL_W-1:0] mem [CELLS];

  always_comb begin
    sat_col   = (int'(in_column) >= COLUMNS) ? LAST_COL : COL_W'(in_column);
    sat_row   = (int'(in_line) >= ROWS) ? LAST_ROW : ROW_W'(in_line);
    t_col     = in_use_cursor ? cur_col_r : sat_col;
    t_row     = in_use_cursor ? cur_row_r : sat_row;
    t_addr    = ADDR_W'(t_row) * ADDR_W'(COLUMNS) + ADDR_W'(t_col);
    is_nl     = (in_character == CH_LF) || (in_character == CH_CR);
    wrap      = is_nl || (t_col == LAST_COL);
    row_ovf   = (t_row == LAST_ROW);
    pc_col    = wrap ? '0 : t_col + COL_W'(1);
    pc_row    = wrap ? (row_ovf ? LAST_ROW : t_row + ROW_W'(1)) : t_row;
    eff_attr  = (in_attribute == '0) ? def_attr_r : in_attribute;
    at_origin = (cur_col_r == '0) && (cur_row_r == '0);
    bs_col    = (cur_col_r == '0) ? LAST_COL : cur_col_r - COL_W'(1);
    bs_row    = (cur_col_r == '0) ? cur_row_r - ROW_W'(1) : cur_row_r;
    bs_addr   = ADDR_W'(bs_row) * ADDR_W'(COLUMNS) + ADDR_W'(bs_col);
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    stat_kind   = KIND_IMM;
    case (in_operation)
      OP_PUT_CHAR: begin
        cur_col_nxt = pc_col;
        cur_row_nxt = pc_row;
        stat_kind   = (wrap && row_ovf) ? KIND_SCROLL : KIND_IMM;
      end
      OP_BACKSPACE: begin
        if (!at_origin) begin
          cur_col_nxt = bs_col;
          cur_row_nxt = bs_row;
        end
      end
      OP_CLEAR: begin
        cur_col_nxt = '0;
        cur_row_nxt = '0;
        stat_kind   = KIND_CLEAR;
      end
      OP_MOVE_CURSOR: begin
        cur_col_nxt = sat_col;
        cur_row_nxt = sat_row;
      end
      OP_READ_CELL: stat_kind = KIND_READ;
      default: stat_kind = KIND_IMM;
    endcase
  end

  assign scan_prev = scan_cnt_r - CNT_W'(1);
  assign scan_src  = scan_cnt_r + CNT_W'(COLUMNS);
  assign scan_last = (scan_cnt_r == CNT_W'(CELLS));
  assign stat      = '{kind: stat_kind, scan_last: scan_last,
                       out_free: (!out_valid_r || out_ready)};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_prev[ADDR_W-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = t_addr;
    if (cmd.scan_run) begin
      if (scan_cnt_r != '0) begin
        mem_we = 1'b1;
        case (cmd.scan_mode)
          SCAN_CLEAR:  mem_wdata = {def_attr_r, CH_BLANK};
          SCAN_SCROLL: mem_wdata = (scan_prev < CNT_W'(CELLS - COLUMNS)) ? mem_q : '0;
          default:     mem_wdata = '0;
        endcase
      end
      if ((cmd.scan_mode == SCAN_SCROLL) && (scan_cnt_r < CNT_W'(CELLS - COLUMNS))) begin
        mem_re    = 1'b1;
        mem_raddr = scan_src[ADDR_W-1:0];
      end
    end else if (cmd.accept) begin
      if ((in_operation == OP_PUT_CHAR) && !is_nl) begin
        mem_we    = 1'b1;
        mem_waddr = t_addr;
        mem_wdata = {eff_attr, in_character};
      end else if ((in_operation == OP_BACKSPACE) && !at_origin) begin
        mem_we    = 1'b1;
        mem_waddr = bs_addr;
        mem_wdata = {def_attr_r, CH_BLANK};
      end
      mem_re = (in_operation == OP_READ_CELL);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_attr_r  <= DEF_ATTR_RESET;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        def_attr_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_run && !scan_last) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_src == OUT_SRC_NXT) begin
        out_col_r <= COLF_W'(cur_col_nxt);
        out_row_r <= LINEF_W'(cur_row_nxt);
      end else begin
        out_col_r <= COLF_W'(cur_col_r);
        out_row_r <= LINEF_W'(cur_row_r);
      end
      out_char_r <= cmd.out_rd ? mem_q[CHAR_W-1:0] : '0;
      out_attr_r <= cmd.out_rd ? mem_q[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_line   = out_row_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer_core.sv
// Top level of the text console writer: controller, datapath and assertions.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       operation, character, attribute, use_cursor, column, line
//   out_ch   source     cursor_column, cursor_line, cell_char, cell_attr
//   cfg_*    write      default attribute, written when cfg_we is high
//
// Put_char without scrolling, backspace, move_cursor and unused codes load their result as they are accepted.
// Read_cell passes through a read state because the grid memory has a registered read port.
// Clear and a put_char that scrolls make a pass over the whole grid, one cell per cycle.
// After reset a pass over the grid zeroes it before in_ch.ready rises.
// A result waits in the output register while the next beat is accepted; a second
// finished result holds the block until the first one is taken.
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_cmd_if.sink                         in_ch,
  tcw_res_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;
  logic      in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_ch.operation),
    .in_character      (in_ch.character),
    .in_attribute      (in_ch.attribute),
    .in_use_cursor     (in_ch.use_cursor),
    .in_column         (in_ch.column),
    .in_line           (in_ch.line),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_cursor_column (out_ch.cursor_column),
    .out_cursor_line   (out_ch.cursor_line),
    .out_cell_char     (out_ch.cell_char),
    .out_cell_attr     (out_ch.cell_attr)
  );

  assign in_ch.ready = in_ready;

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_run |-> !in_ready)
    else $error("input beat offered for acceptance during a grid pass");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten before its beat was taken");

  a_imm_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && (stat.kind == KIND_IMM) && stat.out_free) |=> out_ch.valid)
    else $error("single-cycle command did not present its result");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((int'(out_ch.cursor_column) < COLUMNS) &&
                      (int'(out_ch.cursor_line) < ROWS)))
    else $error("reported cursor lies outside the grid");

endmodule

`default_nettype wire

>>> tb/sv/text_console_writer_check.sv
// Result checker of the text console writer: mirrors the screen and compares every result beat.
`timescale 1ns / 100ps

module text_console_writer_check #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_cmd_if                         cmd_mon,
  tcw_res_if                         res_mon,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  output int                         failures,
  output int                         pending,
  output int                         compared,
  output int                         scrolls
);
  import tcw_pkg::*;

  localparam int CELLS        = COLUMNS * ROWS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COLF_W-1:0]  cursor_column;
    logic [LINEF_W-1:0] cursor_line;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
  } cell_report_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor_pos;
  logic [ATTR_W-1:0] fill_attr;
  int                scroll_total;
  cell_report_t      awaited_reports [$];

  function automatic int unsigned clamp_cell(logic [COLF_W-1:0] col, logic [LINEF_W-1:0] ln);
    int unsigned c;
    int unsigned r;
    c = (col >= COLUMNS) ? COLUMNS - 1 : col;
    r = (ln >= ROWS) ? ROWS - 1 : ln;
    return r * COLUMNS + c;
  endfunction

  // Moving past the last cell shifts the screen up one row and blanks the bottom row.
  function automatic void advance_to(int unsigned pos);
    if (pos >= CELLS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
      pos = CELLS - COLUMNS;
      scroll_total++;
    end
    cursor_pos = pos;
  endfunction

  function automatic cell_report_t predict_report(
      logic [OPER_W-1:0] op, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at, logic uc,
      logic [COLF_W-1:0] col, logic [LINEF_W-1:0] ln);
    cell_report_t      rep;
    int unsigned       spot;
    logic [ATTR_W-1:0] put_attr;
    rep = '0;
    spot = uc ? cursor_pos : clamp_cell(col, ln);
    put_attr = (at == '0) ? fill_attr : at;
    case (op)
      OP_PUT_CHAR: begin
        if (ch == CH_LF || ch == CH_CR) begin
          advance_to((spot / COLUMNS + 1) * COLUMNS);
        end else begin
          screen[spot] = {put_attr, ch};
          advance_to(spot + 1);
        end
      end
      OP_BACKSPACE: begin
        if (cursor_pos != 0) begin
          cursor_pos--;
          screen[cursor_pos] = {fill_attr, CH_BLANK};
        end
      end
      OP_CLEAR: begin
        foreach (screen[i]) screen[i] = {fill_attr, CH_BLANK};
        cursor_pos = 0;
      end
      OP_MOVE_CURSOR: begin
        cursor_pos = clamp_cell(col, ln);
      end
      OP_READ_CELL: begin
        {rep.cell_attr, rep.cell_char} = screen[spot];
      end
      default: begin
      end
    endcase
    rep.cursor_column = COLF_W'(cursor_pos % COLUMNS);
    rep.cursor_line   = LINEF_W'(cursor_pos / COLUMNS);
    return rep;
  endfunction

  always @(posedge clk) begin
    cell_report_t seen;
    cell_report_t want;
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = '0;
      cursor_pos = 0;
      fill_attr = DEF_ATTR_RESET;
      scroll_total = 0;
      awaited_reports.delete();
      failures <= 0;
      compared <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen = {res_mon.cursor_column, res_mon.cursor_line, res_mon.cell_char, res_mon.cell_attr};
        if (awaited_reports.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: cursor %0d,%0d cell %h/%h",
                     $time, seen.cursor_column, seen.cursor_line, seen.cell_char,
                     seen.cell_attr);
          failures <= failures + 1;
        end else begin
          want = awaited_reports.pop_front();
          compared <= compared + 1;
          if (seen.cursor_column !== want.cursor_column || seen.cursor_line !== want.cursor_line
              || seen.cell_char !== want.cell_char || seen.cell_attr !== want.cell_attr) begin
            if (failures < REPORT_LIMIT)
              $display("%0t: mismatch: expected cursor %0d,%0d cell %h/%h, got %0d,%0d cell %h/%h",
                       $time, want.cursor_column, want.cursor_line, want.cell_char,
                       want.cell_attr, seen.cursor_column, seen.cursor_line, seen.cell_char,
                       seen.cell_attr);
            failures <= failures + 1;
          end
        end
      end
      if (cfg_we) fill_attr = cfg_wdata;
      if (cmd_mon.valid && cmd_mon.ready)
        awaited_reports.push_back(predict_report(cmd_mon.operation, cmd_mon.character,
                                                 cmd_mon.attribute, cmd_mon.use_cursor,
                                                 cmd_mon.column, cmd_mon.line));
    end
    pending <= awaited_reports.size();
    scrolls <= scroll_total;
  end

endmodule

>>> tb/sv/text_console_writer_core_test.sv
// Testbench top of the text console writer: command stimulus, flow control and verdict.
`timescale 1ns / 100ps

module text_console_writer_core_test;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 270;
  localparam int STEADY_FIRST = 500;
  localparam int STEADY_LAST  = 720;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [OPER_W-1:0] OP_SPARE_FIRST = OP_READ_CELL + 1'b1;
  localparam logic [OPER_W-1:0] OP_SPARE_LAST  = '1;

  typedef struct packed {
    logic [OPER_W-1:0]  operation;
    logic [CHAR_W-1:0]  character;
    logic [ATTR_W-1:0]  attribute;
    logic               use_cursor;
    logic [COLF_W-1:0]  column;
    logic [LINEF_W-1:0] line;
  } console_cmd_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  int                failures;
  int                pending;
  int                compared;
  int                scrolls;
  int                items_sent;
  int                spare_sent;
  int                settings_used;
  int                op_tally [0:7];
  bit                steady;
  bit                hold_done;

  tcw_cmd_if cmd_bus ();
  tcw_res_if rsp_bus ();

  text_console_writer_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_bus),
    .out_ch   (rsp_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  text_console_writer_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_mon  (cmd_bus),
    .res_mon  (rsp_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .failures (failures),
    .pending  (pending),
    .compared (compared),
    .scrolls  (scrolls)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic console_cmd_t compose_cmd(logic [OPER_W-1:0] op, logic [CHAR_W-1:0] ch,
      logic [ATTR_W-1:0] at, logic uc, logic [COLF_W-1:0] col, logic [LINEF_W-1:0] ln);
    console_cmd_t c;
    c = '{operation: op, character: ch, attribute: at, use_cursor: uc, column: col, line: ln};
    return c;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int unsigned  pick;
    pick = $urandom_range(999);
    c.operation  = OP_PUT_CHAR;
    c.character  = CHAR_W'($urandom);
    c.attribute  = ($urandom_range(4) == 0) ? '0 : ATTR_W'($urandom);
    c.use_cursor = 1'($urandom_range(1));
    c.column     = COLF_W'($urandom);
    c.line       = LINEF_W'($urandom);
    if (pick < 560) begin
      c.use_cursor = ($urandom_range(9) != 0);
      if ($urandom_range(11) == 0) c.character = $urandom_range(1) ? CH_LF : CH_CR;
    end else if (pick < 660) begin
      c.operation = OP_BACKSPACE;
    end else if (pick < 770) begin
      c.operation = OP_MOVE_CURSOR;
    end else if (pick < 975) begin
      c.operation = OP_READ_CELL;
    end else if (pick < 985) begin
      c.operation = OP_CLEAR;
    end else begin
      c.operation = OPER_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end
    return c;
  endfunction

  task automatic offer_command(input console_cmd_t c);
    while (!steady && $urandom_range(99) < 25) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.operation  <= c.operation;
    cmd_bus.character  <= c.character;
    cmd_bus.attribute  <= c.attribute;
    cmd_bus.use_cursor <= c.use_cursor;
    cmd_bus.column     <= c.column;
    cmd_bus.line       <= c.line;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    items_sent++;
    if (c.operation > OP_READ_CELL) spare_sent++;
    else op_tally[c.operation]++;
  endtask

  // The attribute register only changes once every result of the previous phase is back.
  task automatic settle_and_set(input logic [ATTR_W-1:0] value);
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 25);
      @(posedge clk);
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.operation  <= OP_PUT_CHAR;
    cmd_bus.character  <= '0;
    cmd_bus.attribute  <= '0;
    cmd_bus.use_cursor <= 1'b0;
    cmd_bus.column     <= '0;
    cmd_bus.line       <= '0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_BACKSPACE, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_PUT_CHAR, 8'h41, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_PUT_CHAR, 8'hFF, 8'hFF, 1'b0, 7'd127, 5'd31));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b0, 7'd79, 5'd23));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_MOVE_CURSOR, 8'h00, 8'h00, 1'b1, 7'd127, 5'd31));
    offer_command(compose_cmd(OP_PUT_CHAR, CH_LF, 8'h1E, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_MOVE_CURSOR, 8'h00, 8'h00, 1'b0, 7'd5, 5'd3));
    offer_command(compose_cmd(OP_PUT_CHAR, CH_CR, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_PUT_CHAR, CH_LF, 8'h00, 1'b0, 7'd10, 5'd24));
    offer_command(compose_cmd(OP_MOVE_CURSOR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd4));
    offer_command(compose_cmd(OP_BACKSPACE, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_CLEAR, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b0, 7'd40, 5'd12));
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
      offer_command(compose_cmd(OPER_W'(code), 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31));
    offer_command(compose_cmd(OP_PUT_CHAR, 8'h00, 8'h80, 1'b0, 7'd0, 5'd0));
    settle_and_set(8'h00);
    offer_command(compose_cmd(OP_PUT_CHAR, 8'h7A, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b0, 7'd1, 5'd0));
    offer_command(compose_cmd(OP_BACKSPACE, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
    offer_command(compose_cmd(OP_READ_CELL, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));

    phase_attr[0] = 8'hFF;
    phase_attr[1] = ATTR_W'($urandom_range(254, 1));
    phase_attr[2] = 8'h00;
    phase_attr[3] = ATTR_W'($urandom_range(254, 1));
    phase_attr[4] = DEF_ATTR_RESET;
    for (int p = 0; p < PHASES; p++) begin
      settle_and_set(phase_attr[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        steady = (p * PHASE_ITEMS + k >= STEADY_FIRST) && (p * PHASE_ITEMS + k < STEADY_LAST);
        offer_command(random_command());
      end
    end
    steady = 1'b0;

    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d put_char, %0d backspace, %0d clear, %0d move, %0d read, %0d spare",
             items_sent, op_tally[OP_PUT_CHAR], op_tally[OP_BACKSPACE], op_tally[OP_CLEAR],
             op_tally[OP_MOVE_CURSOR], op_tally[OP_READ_CELL], spare_sent);
    $display("Compared %0d result beats over %0d default attribute settings, %0d scrolls",
             compared, settings_used, scrolls);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
